FILE: design/swc_pkg.sv
// Shared types, command codes and constant tables for the square-wave channel.
package swc_pkg;

    // Function codes carried in s_tuser
    localparam logic [2:0] FUNC_CTRL    = 3'd0;
    localparam logic [2:0] FUNC_SWEEP   = 3'd1;
    localparam logic [2:0] FUNC_PER_LO  = 3'd2;
    localparam logic [2:0] FUNC_PER_HI  = 3'd3;
    localparam logic [2:0] FUNC_ENABLE  = 3'd4;
    localparam logic [2:0] FUNC_TICK    = 3'd5;
    localparam logic [2:0] FUNC_QUARTER = 3'd6;
    localparam logic [2:0] FUNC_HALF    = 3'd7;

    // Decoded command, one-hot
    typedef enum logic [7:0] {
        CMD_CTRL    = 8'b0000_0001,
        CMD_SWEEP   = 8'b0000_0010,
        CMD_PER_LO  = 8'b0000_0100,
        CMD_PER_HI  = 8'b0000_1000,
        CMD_ENABLE  = 8'b0001_0000,
        CMD_TICK    = 8'b0010_0000,
        CMD_QUARTER = 8'b0100_0000,
        CMD_HALF    = 8'b1000_0000
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } entry_t;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [10:0] PERIOD_MAX = 11'h7ff;
    localparam logic [10:0] PERIOD_MIN = 11'd8;

    localparam logic [7:0] DUTY_TABLE [4] = '{8'h40, 8'h60, 8'h78, 8'h9f};

    localparam logic [7:0] LENGTH_TABLE [32] = '{
        8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
        8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
        8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
        8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
    };

endpackage

FILE: design/swc_front.sv
// Front end: accepts input transactions and decodes the function code.
module swc_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [2:0]          s_func,
    input  logic [7:0]          s_data,
    input  logic                q_ready,
    output logic                q_push,
    output swc_pkg::entry_t     q_entry
);
    import swc_pkg::*;

    cmd_t cmd;

    always_comb begin
        unique case (s_func)
            FUNC_CTRL:    cmd = CMD_CTRL;
            FUNC_SWEEP:   cmd = CMD_SWEEP;
            FUNC_PER_LO:  cmd = CMD_PER_LO;
            FUNC_PER_HI:  cmd = CMD_PER_HI;
            FUNC_ENABLE:  cmd = CMD_ENABLE;
            FUNC_TICK:    cmd = CMD_TICK;
            FUNC_QUARTER: cmd = CMD_QUARTER;
            FUNC_HALF:    cmd = CMD_HALF;
            default:      cmd = CMD_TICK;
        endcase
    end

    assign s_tready     = q_ready;
    assign q_push       = s_tvalid & q_ready;
    assign q_entry.cmd  = cmd;
    assign q_entry.data = s_data;

endmodule

FILE: design/swc_queue.sv
// Short command queue between the front end and the channel core.
module swc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  swc_pkg::entry_t push_entry,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output swc_pkg::entry_t pop_entry
);
    import swc_pkg::*;

    entry_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic [QUEUE_AW:0]     count_next;
    logic                  do_push;
    logic                  do_pop;

    assign push_ready = count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/swc_core.sv
// Channel core: timer, sequencer, envelope, length counter, sweep and output stage.
module swc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr_en,
    input  logic            cfg_wr_data,
    input  logic            q_valid,
    input  swc_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic [3:0]      m_sample,
    output logic            m_length_active,
    output logic            m_tvalid,
    input  logic            m_tready
);
    import swc_pkg::*;

    logic        neg_carry_reg;
    logic        enabled_reg;
    logic [10:0] period_reg;
    logic [10:0] timer_reg;
    logic [7:0]  duty_reg;
    logic [2:0]  seq_reg;
    logic [3:0]  env_div_reg;
    logic [3:0]  env_decay_reg;
    logic [3:0]  env_vol_reg;
    logic        env_start_reg;
    logic        env_loop_reg;
    logic        env_const_reg;
    logic [7:0]  len_reg;
    logic        len_halt_reg;
    logic [2:0]  sw_div_reg;
    logic [2:0]  sw_period_reg;
    logic [2:0]  sw_shift_reg;
    logic        sw_negate_reg;
    logic        sw_enable_reg;
    logic        sw_reload_reg;

    // Pipeline control: p_valid marks state updated but level not yet captured
    logic        p_valid_reg;
    logic        out_valid_reg;
    logic [3:0]  out_sample_reg;
    logic        out_len_reg;
    logic        p_adv;
    logic        exec;

    logic [15:0] delta;
    logic [15:0] delta_neg;
    logic [15:0] target_sum;
    logic [15:0] target;
    logic        muted;
    logic [3:0]  level;
    logic [7:0]  d;

    assign d = q_entry.data;

    // Sweep target and mute, from the current period
    always_comb begin
        delta      = {5'd0, period_reg >> sw_shift_reg};
        delta_neg  = ~delta + {15'd0, neg_carry_reg};
        target_sum = {5'd0, period_reg} + (sw_negate_reg ? delta_neg : delta);
        target     = target_sum[15] ? 16'd0 : target_sum;
        muted      = (period_reg < PERIOD_MIN) || (target > {5'd0, PERIOD_MAX});
    end

    always_comb begin
        if (!enabled_reg || muted || len_reg == 8'd0 || !duty_reg[seq_reg]) begin
            level = 4'd0;
        end else begin
            level = env_const_reg ? env_vol_reg : env_decay_reg;
        end
    end

    assign p_adv = p_valid_reg & (~out_valid_reg | m_tready);
    assign exec  = q_valid & (~p_valid_reg | p_adv);
    assign q_pop = exec;

    assign m_tvalid        = out_valid_reg;
    assign m_sample        = out_sample_reg;
    assign m_length_active = out_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (exec) begin
                p_valid_reg <= 1'b1;
            end else if (p_adv) begin
                p_valid_reg <= 1'b0;
            end
            if (p_adv) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the level of the state left by the previous transaction
    always_ff @(posedge aclk) begin
        if (p_adv) begin
            out_sample_reg <= level;
            out_len_reg    <= len_reg != 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            neg_carry_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            neg_carry_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enabled_reg   <= 1'b0;
            period_reg    <= '0;
            timer_reg     <= '0;
            duty_reg      <= '0;
            seq_reg       <= 3'd7;
            env_div_reg   <= '0;
            env_decay_reg <= '0;
            env_vol_reg   <= '0;
            env_start_reg <= 1'b0;
            env_loop_reg  <= 1'b0;
            env_const_reg <= 1'b0;
            len_reg       <= '0;
            len_halt_reg  <= 1'b0;
            sw_div_reg    <= '0;
            sw_period_reg <= '0;
            sw_shift_reg  <= '0;
            sw_negate_reg <= 1'b0;
            sw_enable_reg <= 1'b0;
            sw_reload_reg <= 1'b0;
        end else if (exec) begin
            unique case (q_entry.cmd)
                CMD_CTRL: begin
                    env_vol_reg   <= d[3:0];
                    env_const_reg <= d[4];
                    env_loop_reg  <= d[5];
                    len_halt_reg  <= d[5];
                    duty_reg      <= DUTY_TABLE[d[7:6]];
                end
                CMD_SWEEP: begin
                    sw_shift_reg  <= d[2:0];
                    sw_negate_reg <= d[3];
                    sw_period_reg <= d[6:4];
                    sw_enable_reg <= d[7];
                    sw_reload_reg <= 1'b1;
                end
                CMD_PER_LO: begin
                    period_reg[7:0] <= d;
                end
                CMD_PER_HI: begin
                    period_reg[10:8] <= d[2:0];
                    if (enabled_reg) begin
                        len_reg <= LENGTH_TABLE[d[7:3]];
                    end
                    env_start_reg <= 1'b1;
                    seq_reg       <= 3'd7;
                end
                CMD_ENABLE: begin
                    enabled_reg <= d[0];
                    if (!d[0]) begin
                        len_reg <= '0;
                    end
                end
                CMD_TICK: begin
                    if (timer_reg != '0) begin
                        timer_reg <= timer_reg - 1'b1;
                    end else begin
                        timer_reg <= period_reg;
                        seq_reg   <= seq_reg - 1'b1;
                    end
                end
                CMD_QUARTER: begin
                    if (env_start_reg) begin
                        env_start_reg <= 1'b0;
                        env_decay_reg <= 4'd15;
                        env_div_reg   <= env_vol_reg;
                    end else if (env_div_reg != '0) begin
                        env_div_reg <= env_div_reg - 1'b1;
                    end else begin
                        env_div_reg <= env_vol_reg;
                        if (env_decay_reg != '0) begin
                            env_decay_reg <= env_decay_reg - 1'b1;
                        end else if (env_loop_reg) begin
                            env_decay_reg <= 4'd15;
                        end
                    end
                end
                CMD_HALF: begin
                    if (!len_halt_reg && len_reg != '0) begin
                        len_reg <= len_reg - 1'b1;
                    end
                    if (sw_div_reg == '0 && sw_enable_reg && sw_shift_reg != '0 && !muted) begin
                        period_reg <= target[10:0];
                    end
                    if (sw_div_reg == '0 || sw_reload_reg) begin
                        sw_div_reg    <= sw_period_reg;
                        sw_reload_reg <= 1'b0;
                    end else begin
                        sw_div_reg <= sw_div_reg - 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: design/square_wave_channel_top.sv
// Top level of the square-wave sound channel.
//
// Input channel (s_): one transaction per command. s_tuser holds the function
// code (control, sweep, period low, period high/length, enable, timer tick,
// quarter-frame, half-frame) and s_tdata the written byte.
// Output channel (m_): exactly one transaction per input transaction, in order,
// carrying the 4-bit sample and the length-active flag after that command.
// cfg_wr_en/cfg_wr_data write the sweep negate carry (0 ones', 1 twos'
// complement); write it only while the channel is idle.
// Throughput: one transaction per clock while the receiver is ready. A front
// decoder pushes into a four-entry queue; the core executes one command per
// cycle from the queue and then latches the resulting level into the output
// register, which drives m_.
// When the receiver stalls, the output register and the core hold, the queue
// fills and s_tready drops once four commands are waiting.
// Reset (aresetn low, synchronous) empties the queue and output stage and
// returns all channel state to its idle values; no clearing pass is needed.
module square_wave_channel_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,   // sweep_negate_carry
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,       // [7:0] data
    input  logic [2:0] s_tuser,       // [2:0] func
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata        // [3:0] sample, [4] length_active, [7:5] zero
);
    import swc_pkg::*;

    entry_t     push_entry;
    entry_t     pop_entry;
    logic       q_push;
    logic       q_ready;
    logic       q_pop;
    logic       q_valid;
    logic [3:0] sample;
    logic       length_active;

    swc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_func   (s_tuser),
        .s_data   (s_tdata),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    swc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_entry  (pop_entry)
    );

    swc_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .q_valid         (q_valid),
        .q_entry         (pop_entry),
        .q_pop           (q_pop),
        .m_sample        (sample),
        .m_length_active (length_active),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready)
    );

    assign m_tdata = {3'b000, length_active, sample};

endmodule

FILE: test/square_wave_channel_top_tb.sv
// Self-checking testbench for the square-wave channel: directed script, random notes, predictor.
module square_wave_channel_top_tb;
    import swc_pkg::*;

    // Duty patterns and length loads, lowest entry in the lowest byte
    localparam logic [31:0] DUTY_BITS = {8'h9f, 8'h78, 8'h60, 8'h40};
    localparam logic [255:0] LENGTH_BYTES = {
        8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24,  8'd192,
        8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16,  8'd12,
        8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8,   8'd160,
        8'd6,  8'd80, 8'd4,  8'd40, 8'd2,  8'd20, 8'd254, 8'd10
    };

    typedef struct packed {
        logic        enabled;
        logic [10:0] period;
        logic [10:0] count;
        logic [7:0]  duty;
        logic [2:0]  pos;
        logic [3:0]  env_div;
        logic [3:0]  env_decay;
        logic [3:0]  env_vol;
        logic        env_start;
        logic        env_loop;
        logic        env_const;
        logic [7:0]  length;
        logic        halt;
        logic [2:0]  sw_div;
        logic [2:0]  sw_per;
        logic [2:0]  sw_shift;
        logic        sw_neg;
        logic        sw_en;
        logic        sw_reload;
    } chan_state_t;

    typedef struct packed {
        logic [3:0] sample;
        logic       active;
    } level_t;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic       typed;
        logic [3:0] sample;
        logic       active;
    } script_row_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic       cfg_wr_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data
    logic [2:0] s_tuser;    // [2:0] func
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [3:0] sample, [4] length_active

    chan_state_t ch;
    logic        negate_carry;
    level_t      pending_levels [$];
    int          commands_sent;
    int          results_checked;
    int          audible_results;
    int          mismatches;
    int          burst_left;
    int          rx_cycle;
    int          rx_mode;

    script_row_t opening_script [25] = '{
        '{FUNC_TICK,    8'hff, 1'b1, 4'd0, 1'b0},
        '{FUNC_CTRL,    8'hbf, 1'b1, 4'd0, 1'b0},
        '{FUNC_ENABLE,  8'h01, 1'b1, 4'd0, 1'b0},
        '{FUNC_PER_LO,  8'hff, 1'b1, 4'd0, 1'b0},
        // period 0x7ff: unnegated target overflows and mutes
        '{FUNC_PER_HI,  8'h0f, 1'b1, 4'd0, 1'b1},
        '{FUNC_TICK,    8'h00, 1'b1, 4'd0, 1'b1},
        // negate with shift zero: ones' complement gives target zero
        '{FUNC_SWEEP,   8'h08, 1'b0, 4'd0, 1'b0},
        '{FUNC_QUARTER, 8'h00, 1'b0, 4'd0, 1'b0},
        '{FUNC_TICK,    8'hff, 1'b0, 4'd0, 1'b0},
        '{FUNC_CTRL,    8'h05, 1'b0, 4'd0, 1'b0},
        '{FUNC_HALF,    8'h00, 1'b0, 4'd0, 1'b0},
        '{FUNC_SWEEP,   8'hf9, 1'b0, 4'd0, 1'b0},
        '{FUNC_HALF,    8'hff, 1'b0, 4'd0, 1'b0},
        '{FUNC_TICK,    8'h00, 1'b0, 4'd0, 1'b0},
        '{FUNC_PER_LO,  8'h03, 1'b0, 4'd0, 1'b0},
        // period below eight mutes; length loads from the first entry
        '{FUNC_PER_HI,  8'h00, 1'b1, 4'd0, 1'b1},
        '{FUNC_CTRL,    8'h20, 1'b0, 4'd0, 1'b0},
        '{FUNC_HALF,    8'h00, 1'b0, 4'd0, 1'b0},
        '{FUNC_ENABLE,  8'h00, 1'b1, 4'd0, 1'b0},
        // disabled channel ignores the length load
        '{FUNC_PER_HI,  8'hf8, 1'b1, 4'd0, 1'b0},
        '{FUNC_ENABLE,  8'hff, 1'b1, 4'd0, 1'b0},
        '{FUNC_PER_HI,  8'hf8, 1'b0, 4'd0, 1'b0},
        '{FUNC_CTRL,    8'hdf, 1'b0, 4'd0, 1'b0},
        '{FUNC_PER_LO,  8'h10, 1'b0, 4'd0, 1'b0},
        '{FUNC_TICK,    8'h00, 1'b0, 4'd0, 1'b0}
    };

    square_wave_channel_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic logic [15:0] retune_target();
        logic [15:0] delta;
        logic [15:0] sum;
        delta = {5'd0, ch.period} >> ch.sw_shift;
        if (ch.sw_neg) begin
            delta = ~delta + {15'd0, negate_carry};
        end
        sum = {5'd0, ch.period} + delta;
        if (sum[15]) begin
            sum = 16'd0;
        end
        return sum;
    endfunction

    function automatic logic channel_silenced();
        return ch.period < 11'd8 || retune_target() > 16'h07ff;
    endfunction

    function automatic level_t advance_channel(input logic [2:0] f, input logic [7:0] d);
        level_t      lvl;
        logic [15:0] tgt;
        case (f)
            FUNC_CTRL: begin
                ch.env_vol   = d[3:0];
                ch.env_const = d[4];
                ch.env_loop  = d[5];
                ch.halt      = d[5];
                ch.duty      = DUTY_BITS[{d[7:6], 3'b000} +: 8];
            end
            FUNC_SWEEP: begin
                ch.sw_shift  = d[2:0];
                ch.sw_neg    = d[3];
                ch.sw_per    = d[6:4];
                ch.sw_en     = d[7];
                ch.sw_reload = 1'b1;
            end
            FUNC_PER_LO: ch.period[7:0] = d;
            FUNC_PER_HI: begin
                ch.period[10:8] = d[2:0];
                if (ch.enabled) begin
                    ch.length = LENGTH_BYTES[{d[7:3], 3'b000} +: 8];
                end
                ch.env_start = 1'b1;
                ch.pos       = 3'd7;
            end
            FUNC_ENABLE: begin
                ch.enabled = d[0];
                if (!d[0]) begin
                    ch.length = 8'd0;
                end
            end
            FUNC_TICK: begin
                if (ch.count != 11'd0) begin
                    ch.count = ch.count - 11'd1;
                end else begin
                    ch.count = ch.period;
                    ch.pos   = ch.pos - 3'd1;
                end
            end
            FUNC_QUARTER: begin
                if (ch.env_start) begin
                    ch.env_start = 1'b0;
                    ch.env_decay = 4'd15;
                    ch.env_div   = ch.env_vol;
                end else if (ch.env_div != 4'd0) begin
                    ch.env_div = ch.env_div - 4'd1;
                end else begin
                    ch.env_div = ch.env_vol;
                    if (ch.env_decay != 4'd0) begin
                        ch.env_decay = ch.env_decay - 4'd1;
                    end else if (ch.env_loop) begin
                        ch.env_decay = 4'd15;
                    end
                end
            end
            default: begin
                if (!ch.halt && ch.length != 8'd0) begin
                    ch.length = ch.length - 8'd1;
                end
                tgt = retune_target();
                if (ch.sw_div == 3'd0 && ch.sw_en && ch.sw_shift != 3'd0 && !channel_silenced()) begin
                    ch.period = tgt[10:0];
                end
                if (ch.sw_div == 3'd0 || ch.sw_reload) begin
                    ch.sw_div    = ch.sw_per;
                    ch.sw_reload = 1'b0;
                end else begin
                    ch.sw_div = ch.sw_div - 3'd1;
                end
            end
        endcase
        if (!ch.enabled || channel_silenced() || ch.length == 8'd0 || !ch.duty[ch.pos]) begin
            lvl.sample = 4'd0;
        end else begin
            lvl.sample = ch.env_const ? ch.env_vol : ch.env_decay;
        end
        lvl.active = ch.length != 8'd0;
        return lvl;
    endfunction

    // Send one command in bursts with random gaps; predict at acceptance.
    task automatic send_cmd(input logic [2:0] f, input logic [7:0] d,
                            input logic typed = 1'b0, input logic [3:0] t_sample = 4'd0,
                            input logic t_active = 1'b0);
        int     gap;
        level_t lvl;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 24);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        lvl = advance_channel(f, d);
        if (typed) begin
            lvl.sample = t_sample;
            lvl.active = t_active;
        end
        pending_levels.push_back(lvl);
        commands_sent++;
    endtask

    task automatic drain_channel();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_levels.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_negate_carry(input logic v);
        drain_channel();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        negate_carry = v;
    endtask

    // Mostly whole notes (setup writes, then clocking), the rest raw noise.
    task automatic run_random_phase(input int budget);
        int stop_at;
        int n;
        int pick;
        stop_at = commands_sent + budget;
        while (commands_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7) begin
                send_cmd(FUNC_ENABLE, {7'($urandom), ($urandom_range(0, 9) != 0)});
                send_cmd(FUNC_CTRL, 8'($urandom));
                if ($urandom_range(0, 1) == 0) begin
                    send_cmd(FUNC_SWEEP, 8'($urandom));
                end
                send_cmd(FUNC_PER_LO, ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                   : 8'($urandom_range(8, 40)));
                send_cmd(FUNC_PER_HI, {5'($urandom), ($urandom_range(0, 4) == 0) ? 3'($urandom)
                                                                                 : 3'd0});
                n = $urandom_range(16, 96);
                repeat (n) begin
                    pick = $urandom_range(0, 99);
                    send_cmd(pick < 70 ? FUNC_TICK : (pick < 88 ? FUNC_QUARTER : FUNC_HALF),
                             8'($urandom));
                end
            end else begin
                n = $urandom_range(1, 8);
                repeat (n) send_cmd(3'($urandom), 8'($urandom));
            end
        end
    endtask

    // Check results and drive a changing stall pattern on the receive side.
    always @(posedge aclk) begin
        level_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_levels.size() == 0) begin
                $display("%0t: unexpected result, sample %0d length_active %0b",
                         $time, m_tdata[3:0], m_tdata[4]);
                mismatches++;
            end else begin
                want = pending_levels.pop_front();
                results_checked++;
                if (m_tdata[3:0] != 4'd0) begin
                    audible_results++;
                end
                if (m_tdata[3:0] !== want.sample) begin
                    $display("%0t: sample expected %0d actual %0d",
                             $time, want.sample, m_tdata[3:0]);
                    mismatches++;
                end
                if (m_tdata[4] !== want.active) begin
                    $display("%0t: length_active expected %0b actual %0b",
                             $time, want.active, m_tdata[4]);
                    mismatches++;
                end
            end
        end
        rx_cycle++;
        if (rx_cycle % 200 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom);
            2: m_tready <= (rx_cycle % 5) > 1;
            default: m_tready <= (rx_cycle % 32) < 12;
        endcase
    end

    initial begin
        #4000000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = 8'd0;
        s_tuser     = FUNC_TICK;
        m_tready    = 1'b0;
        ch          = '0;
        ch.pos      = 3'd7;
        negate_carry    = 1'b0;
        commands_sent   = 0;
        results_checked = 0;
        audible_results = 0;
        mismatches      = 0;
        burst_left      = 0;
        rx_cycle        = 0;
        rx_mode         = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_negate_carry(1'b0);
        for (int i = 0; i < 25; i++) begin
            send_cmd(opening_script[i].func, opening_script[i].data, opening_script[i].typed,
                     opening_script[i].sample, opening_script[i].active);
        end

        write_negate_carry(1'b1);
        run_random_phase(630);
        write_negate_carry(1'b0);
        run_random_phase(630);
        write_negate_carry(1'b1);
        run_random_phase(630);
        drain_channel();
        repeat (4) @(posedge aclk);

        $display("Sent %0d commands and checked %0d results, %0d of them audible.",
                 commands_sent, results_checked, audible_results);
        $display("Sweep negation ran with both ones' and twos' complement carry.");
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
